>>> rtl/core/track_cone_isolation_top_assert.svh
// assertion macros for the track cone isolation block
`ifndef TRACK_CONE_ISOLATION_TOP_ASSERT_SVH
`define TRACK_CONE_ISOLATION_TOP_ASSERT_SVH
`ifndef SYNTH
`define TCI_ASSERT_IMP(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define TCI_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define TCI_ASSERT_IMP(lbl, clk, rst_n, a, c)
`define TCI_ASSERT_NEXT(lbl, clk, rst_n, a, c)
`endif
`endif

>>> rtl/core/tci_pkg.sv
package tci_pkg;
    localparam int MaxTracks = 256;
    localparam int IdxW = $clog2(MaxTracks);
    localparam int CntW = $clog2(MaxTracks + 1);
    localparam logic signed [14:0] PhiHalf = 15'sd3217;
    localparam logic signed [14:0] PhiPeriod = 15'sd6434;
    localparam logic [23:0] SumSat = 24'hFFFFFF;
    localparam logic [8:0] ConeCntSat = 9'd511;
    localparam logic [15:0] RatioSat = 16'hFFFF;

    localparam logic [1:0] OpClear = 2'd0;
    localparam logic [1:0] OpLoad = 2'd1;
    localparam logic [1:0] OpEval = 2'd2;

    localparam logic [1:0] StSkip = 2'd0;
    localparam logic [1:0] StIsoFail = 2'd1;
    localparam logic [1:0] StKinFail = 2'd2;
    localparam logic [1:0] StAccept = 2'd3;

    localparam logic [2:0] RegPtMin = 3'd0;
    localparam logic [2:0] RegRadSq = 3'd1;
    localparam logic [2:0] RegRatioMax = 3'd2;
    localparam logic [2:0] RegSumMax = 3'd3;
    localparam logic [2:0] RegUseSum = 3'd4;
    localparam logic [2:0] RegOutPtMin = 3'd5;
    localparam logic [2:0] RegEtaMax = 3'd6;

    typedef struct packed {
        logic [15:0] pt;
        logic signed [13:0] eta;
        logic signed [12:0] phi;
        logic [15:0] id;
    } t_track;

    typedef struct packed {
        logic start;
        logic [33:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic done;
        logic [15:0] ratio;
    } t_div_rsp;
endpackage

>>> rtl/core/tci_div.sv
// restoring divider, one quotient bit a cycle, saturating to 16 bits
module tci_div import tci_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);
    logic [33:0] r_quo, n_quo;
    logic [16:0] r_rem, n_rem;
    logic [15:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy, r_done;
    logic [16:0] w_trial;

    always_comb begin
        w_trial = {r_rem[15:0], r_quo[33]};
        n_quo = {r_quo[32:0], 1'b0};
        n_rem = w_trial;
        if (w_trial >= {1'b0, r_den}) begin
            n_rem = w_trial - {1'b0, r_den};
            n_quo[0] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd34;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quo <= i_req.dividend;
            r_rem <= '0;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.ratio = (r_den == 16'd0 || r_quo[33:16] != '0) ? RatioSat : r_quo[15:0];
endmodule

>>> rtl/core/tci_cone.sv
// cone test and pt accumulate for one stored track per cycle while enabled
module tci_cone import tci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_clr,
    input  logic        i_en,
    input  t_track      i_cand,
    input  t_track      i_trk,
    input  logic [23:0] i_rad_sq,
    output logic [23:0] o_sum,
    output logic [8:0]  o_cnt
);
    logic signed [14:0] w_de, w_dp;
    logic signed [14:0] w_dpw;
    logic signed [29:0] w_de2, w_dp2;
    logic [29:0] w_r2;
    logic [24:0] w_sum;

    always_comb begin
        w_de = 15'(i_cand.eta) - 15'(i_trk.eta);
        w_dp = 15'(i_cand.phi) - 15'(i_trk.phi);
        if (w_dp > PhiHalf) w_dpw = w_dp - PhiPeriod;
        else if (w_dp < -PhiHalf) w_dpw = w_dp + PhiPeriod;
        else w_dpw = w_dp;
        // full width squares, both are never negative
        w_de2 = w_de * w_de;
        w_dp2 = w_dpw * w_dpw;
        w_r2 = $unsigned(w_de2) + $unsigned(w_dp2);
        w_sum = {1'b0, o_sum} + {9'd0, i_trk.pt};
    end

    always_ff @(posedge i_clk) begin
        if (i_clr) begin
            o_sum <= '0;
            o_cnt <= '0;
        end else if (i_en && w_r2 <= {6'd0, i_rad_sq} && i_trk.id != i_cand.id) begin
            o_sum <= w_sum[24] ? SumSat : w_sum[23:0];
            if (o_cnt != ConeCntSat) o_cnt <= o_cnt + 9'd1;
        end
    end
endmodule

>>> rtl/core/track_cone_isolation_top.sv
// channel | dir | signals                                  | accepted when
// in      | in  | i_valid, o_ready, i_opcode..i_object_id  | i_valid & o_ready
// out     | out | o_valid, i_ready, o_status..o_tracks_dropped | o_valid & i_ready
// cfg     | in  | psel, penable, pwrite, paddr, pwdata     | psel & penable & pwrite
// clear and load requests leave the sequencer idle, so ready stays high
// an evaluate request walks the store one read a cycle (no walk when the
// store is empty), then waits in the divider state until the divider is
// done, grades the result and moves to the output state, where o_valid is
// high; a low pt candidate goes there the cycle after acceptance
// reset is synchronous, active low; the track store is not cleared
// ready stays low from an evaluate until its result is taken
module track_cone_isolation_top import tci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_opcode,
    input  logic [15:0] i_pt,
    input  logic signed [13:0] i_eta,
    input  logic signed [12:0] i_phi,
    input  logic [15:0] i_object_id,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_status,
    output logic [15:0] o_iso_ratio,
    output logic [23:0] o_cone_sum,
    output logic [8:0]  o_cone_count,
    output logic        o_tracks_dropped,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
`include "track_cone_isolation_top_assert.svh"

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_WALK = 5'b00010,
        S_LAST = 5'b00100,
        S_DIV  = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state r_state;
    // config registers
    logic [15:0] r_pt_min, r_ratio_max, r_out_pt_min;
    logic [23:0] r_rad_sq, r_sum_max;
    logic        r_use_sum;
    logic [12:0] r_eta_max;
    // event state
    logic [CntW-1:0] r_count;
    logic            r_ovf;
    t_track          r_mem [MaxTracks];
    t_track          r_rd;
    t_track          r_cand;
    logic [CntW-1:0] r_idx;
    logic            r_rd_vld;
    logic            r_low;
    logic [1:0]      r_status;
    logic [15:0]     r_ratio;
    logic [23:0]     w_sum;
    logic [8:0]      w_cnt;
    logic            w_acc_in, w_cfg_wr, w_clr;
    t_div_req        w_div_req;
    t_div_rsp        w_div_rsp;
    logic [13:0]     w_abs_eta;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite;
    assign o_ready  = (r_state == S_IDLE);
    assign w_acc_in = i_valid & o_ready;
    assign o_valid  = (r_state == S_OUT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pt_min <= 16'd8;  r_rad_sq <= 24'd262144; r_ratio_max <= 16'd102;
            r_sum_max <= 24'd80; r_use_sum <= 1'b0; r_out_pt_min <= 16'd160;
            r_eta_max <= 13'd2458;
        end else if (w_cfg_wr) begin
            case (paddr[4:2])
                RegPtMin:    r_pt_min <= pwdata[15:0];
                RegRadSq:    r_rad_sq <= pwdata[23:0];
                RegRatioMax: r_ratio_max <= pwdata[15:0];
                RegSumMax:   r_sum_max <= pwdata[23:0];
                RegUseSum:   r_use_sum <= pwdata[0];
                RegOutPtMin: r_out_pt_min <= pwdata[15:0];
                RegEtaMax:   r_eta_max <= pwdata[12:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            RegPtMin:    prdata = {16'd0, r_pt_min};
            RegRadSq:    prdata = {8'd0, r_rad_sq};
            RegRatioMax: prdata = {16'd0, r_ratio_max};
            RegSumMax:   prdata = {8'd0, r_sum_max};
            RegUseSum:   prdata = {31'd0, r_use_sum};
            RegOutPtMin: prdata = {16'd0, r_out_pt_min};
            RegEtaMax:   prdata = {19'd0, r_eta_max};
            default:     prdata = '0;
        endcase
    end

    // track store, one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (w_acc_in && i_opcode == OpLoad && i_pt >= r_pt_min
                && r_count != CntW'(MaxTracks))
            r_mem[r_count[IdxW-1:0]] <= '{pt: i_pt, eta: i_eta, phi: i_phi, id: i_object_id};
        r_rd <= r_mem[r_idx[IdxW-1:0]];
    end

    assign w_clr = w_acc_in;

    tci_cone u_cone (
        .i_clk   (i_clk),
        .i_clr   (w_clr),
        .i_en    (r_rd_vld),
        .i_cand  (r_cand),
        .i_trk   (r_rd),
        .i_rad_sq(r_rad_sq),
        .o_sum   (w_sum),
        .o_cnt   (w_cnt)
    );

    assign w_div_req.start    = (r_state == S_LAST) && !r_rd_vld;
    assign w_div_req.dividend = {w_sum, 10'd0};
    assign w_div_req.divisor  = r_cand.pt;

    tci_div u_div (
        .i_clk (i_clk),
        .i_rst_n(i_rst_n),
        .i_req (w_div_req),
        .o_rsp (w_div_rsp)
    );

    assign w_abs_eta = r_cand.eta[13] ? 14'(-r_cand.eta) : 14'(r_cand.eta);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_rd_vld <= 1'b0;
            r_idx    <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_idx    <= '0;
                    r_rd_vld <= 1'b0;
                    if (w_acc_in) begin
                        case (i_opcode)
                            OpClear: begin
                                r_count <= '0;
                                r_ovf   <= 1'b0;
                            end
                            OpLoad: begin
                                if (i_pt >= r_pt_min) begin
                                    if (r_count != CntW'(MaxTracks)) r_count <= r_count + 1'b1;
                                    else r_ovf <= 1'b1;
                                end
                            end
                            OpEval: begin
                                r_cand <= '{pt: i_pt, eta: i_eta, phi: i_phi, id: i_object_id};
                                r_low  <= (i_pt < r_pt_min);
                                if (i_pt < r_pt_min) r_state <= S_OUT;
                                else if (r_count == '0) r_state <= S_LAST;
                                else r_state <= S_WALK;
                            end
                            default: ;
                        endcase
                    end
                end
                S_WALK: begin
                    // read address runs one ahead of the accumulator
                    r_rd_vld <= 1'b1;
                    r_idx    <= r_idx + 1'b1;
                    if (r_idx + 1'b1 == r_count) r_state <= S_LAST;
                end
                S_LAST: begin
                    r_rd_vld <= 1'b0;
                    if (!r_rd_vld) r_state <= S_DIV;
                end
                S_DIV: begin
                    if (w_div_rsp.done) begin
                        r_ratio <= w_div_rsp.ratio;
                        if ((r_use_sum && w_sum > r_sum_max) || w_div_rsp.ratio > r_ratio_max)
                            r_status <= StIsoFail;
                        else if (r_cand.pt > r_out_pt_min && w_abs_eta < {1'b0, r_eta_max})
                            r_status <= StAccept;
                        else
                            r_status <= StKinFail;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (i_ready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // low pt candidates report zeros with the overflow flag
    assign o_status         = r_low ? StSkip : r_status;
    assign o_iso_ratio      = r_low ? 16'd0 : r_ratio;
    assign o_cone_sum       = r_low ? 24'd0 : w_sum;
    assign o_cone_count     = r_low ? 9'd0 : w_cnt;
    assign o_tracks_dropped = r_ovf;

    `TCI_ASSERT_IMP(a_cnt_max, i_clk, i_rst_n, 1'b1, r_count <= CntW'(MaxTracks))
    `TCI_ASSERT_IMP(a_busy_not_ready, i_clk, i_rst_n, r_state != S_IDLE, !o_ready)
    `TCI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    `TCI_ASSERT_IMP(a_walk_bound, i_clk, i_rst_n, r_state == S_WALK, r_idx < r_count)
endmodule
